FILE: sv/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg: shared types and arithmetic for the Lorenz RK4 step block
// Fixed-point word format, saturating helpers, pipeline buses and codes.
// ----------------------------------------------------------------------------
package lrk_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int SUM_W     = WORD_W + 3;

  localparam int CFG_DW = (WORD_W > 32) ? 64 : 32;
  localparam int CFG_AW = (WORD_W > 32) ? 5 : 4;
  localparam int IDX_LSB = (WORD_W > 32) ? 3 : 2;

  localparam int QDEPTH = 32;
  localparam int QAW    = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef word_t [2:0] vec_t;
  typedef vec_t  [2:0] mat_t;
  typedef sum_t  [2:0] svec_t;
  typedef svec_t [2:0] smat_t;

  localparam logic [1:0] REG_SIGMA = 2'd0;
  localparam logic [1:0] REG_RHO   = 2'd1;
  localparam logic [1:0] REG_BETA  = 2'd2;
  localparam logic [1:0] REG_STEP  = 2'd3;

  localparam word_t WMAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam word_t WMIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});
  localparam word_t ONE_Q = (FRAC_BITS >= WORD_W - 1) ? WMAX :
                            word_t'(64'd1 << FRAC_BITS);
  localparam acc_t RND_BIAS = acc_t'((65'd1 << FRAC_BITS) - 65'd1);

  typedef struct packed {
    logic  clip;
    word_t v;
  } sres_t;

  typedef struct packed {
    word_t sigma;
    word_t rho;
    word_t beta;
    word_t dt;
  } coef_t;

  typedef struct packed {
    logic halve_prev;
    logic halve_next;
    logic use_next;
    logic weight2;
  } mode_t;

  typedef struct packed {
    logic  valid;
    logic  want;
    logic  clip_s;
    logic  clip_j;
    vec_t  u;
    vec_t  p;
    mat_t  kprev;
    svec_t ssum;
    smat_t jsum;
  } bus_t;

  typedef struct packed {
    logic valid;
    logic want;
    logic clip_s;
    logic clip_j;
    vec_t st;
    mat_t jm;
  } res_t;

  function automatic sres_t f_wrap(input logic [WORD_W:0] s);
    sres_t r;
    r.clip = s[WORD_W] ^ s[WORD_W-1];
    r.v = r.clip ? (s[WORD_W] ? WMIN : WMAX) : word_t'(s[WORD_W-1:0]);
    return r;
  endfunction

  function automatic sres_t f_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    return f_wrap(s);
  endfunction

  function automatic sres_t f_sub(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    return f_wrap(s);
  endfunction

  // halve, rounding toward zero
  function automatic word_t f_half(input word_t a);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {{WORD_W{1'b0}}, a[WORD_W-1]};
    return word_t'(s[WORD_W:1]);
  endfunction

  function automatic prod_t f_mul(input word_t a, input word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // drop fraction bits toward zero, then saturate
  function automatic sres_t f_accfin(input acc_t v);
    acc_t  t;
    sres_t r;
    t = v + (v[ACC_W-1] ? RND_BIAS : acc_t'(0));
    t = t >>> FRAC_BITS;
    if ((&t[ACC_W-1:WORD_W-1]) || !(|t[ACC_W-1:WORD_W-1])) begin
      r.clip = 1'b0;
      r.v = word_t'(t[WORD_W-1:0]);
    end else begin
      r.clip = 1'b1;
      r.v = t[ACC_W-1] ? WMIN : WMAX;
    end
    return r;
  endfunction

  function automatic sres_t f_mulfin(input prod_t p);
    return f_accfin(acc_t'(p));
  endfunction

endpackage

FILE: sv/lorenz_rk4_step_with_tangent.sv
// ----------------------------------------------------------------------------
// lorenz_rk4_step_with_tangent: one RK4 step of the Lorenz system
// Pipelined RK4 state update with optional 3x3 step Jacobian output.
// ----------------------------------------------------------------------------
// Output: results are registered; each is taken at the edge that ends the
//   cycle in which it is shown, and tangent rows follow their state directly.
// Throughput: one request per cycle while busy is low; the single result port
//   sends each state and row in turn; at most 32 requests outstanding.
// Reset: synchronous active-low; clears valid bits, queue pointers, request
//   count and loads the default coefficients. Results cannot be stalled.
module lorenz_rk4_step_with_tangent (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  lrk_pkg::word_t               in_pos_x,
  input  lrk_pkg::word_t               in_pos_y,
  input  lrk_pkg::word_t               in_pos_z,
  input  logic                         in_want_tangent,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [1:0]                   out_row_index,
  output lrk_pkg::word_t               out_elem0,
  output lrk_pkg::word_t               out_elem1,
  output lrk_pkg::word_t               out_elem2,
  output logic                         out_saturated,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrk_pkg::CFG_AW-1:0]   paddr,
  input  logic [lrk_pkg::CFG_DW-1:0]   pwdata,
  output logic [lrk_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import lrk_pkg::*;

  // Coefficient regs: user writes only while the pipeline is drained; unchecked
  word_t             sigma_r, rho_r, beta_r;
  logic [WORD_W-2:0] dt_r;
  logic [1:0]        cfg_idx;
  logic              cfg_wr;
  coef_t             coef;

  // Outstanding request count: accepted but not yet fully sent
  logic [QAW:0] count_r, count_nxt;
  logic         accept, pop, full;

  bus_t bus0_r, bus0_nxt, bus1, bus2, bus3, bus4;
  res_t res_c;

  // Stage modes: halving of the incoming K, halving of the next point step,
  // whether a next point exists, and the 1-2-2-1 weights of the average
  localparam mode_t MODE1 = '{halve_prev: 1'b0, halve_next: 1'b1, use_next: 1'b1,
                              weight2: 1'b0};
  localparam mode_t MODE2 = '{halve_prev: 1'b1, halve_next: 1'b1, use_next: 1'b1,
                              weight2: 1'b1};
  localparam mode_t MODE3 = '{halve_prev: 1'b1, halve_next: 1'b0, use_next: 1'b1,
                              weight2: 1'b1};
  localparam mode_t MODE4 = '{halve_prev: 1'b0, halve_next: 1'b0, use_next: 1'b0,
                              weight2: 1'b0};

  assign pready  = 1'b1;
  assign cfg_idx = paddr[IDX_LSB+1:IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= word_t'(655360);
      rho_r   <= word_t'(1835008);
      beta_r  <= word_t'(174763);
      dt_r    <= (WORD_W-1)'(655);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIGMA: sigma_r <= word_t'(pwdata);
        REG_RHO:   rho_r   <= word_t'(pwdata);
        REG_BETA:  beta_r  <= word_t'(pwdata);
        REG_STEP:  dt_r    <= pwdata[WORD_W-2:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIGMA: prdata = CFG_DW'(sigma_r);
      REG_RHO:   prdata = CFG_DW'(rho_r);
      REG_BETA:  prdata = CFG_DW'(beta_r);
      REG_STEP:  prdata = CFG_DW'({1'b0, dt_r});
    endcase
  end

  assign coef = '{sigma: sigma_r, rho: rho_r, beta: beta_r, dt: word_t'({1'b0, dt_r})};

  // Hold off requests when the queue could overflow or during reset
  assign full   = count_r == (QAW+1)'(QDEPTH);
  assign busy   = full || !rst_n;
  assign accept = start && !busy;

  always_comb begin
    count_nxt = count_r;
    if (accept && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!accept && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Launch: the start point is also the first stage point, previous K is zero
  always_comb begin
    bus0_nxt = '0;
    bus0_nxt.valid = accept;
    bus0_nxt.want = in_want_tangent;
    bus0_nxt.u[0] = in_pos_x;
    bus0_nxt.u[1] = in_pos_y;
    bus0_nxt.u[2] = in_pos_z;
    bus0_nxt.p = bus0_nxt.u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bus0_r.valid <= 1'b0;
    end else begin
      count_r <= count_nxt;
      bus0_r <= bus0_nxt;
    end
  end

  lrk_stage u_stage1 (.clk(clk), .rst_n(rst_n), .cfg(coef), .mode(MODE1),
                      .bus_i(bus0_r), .bus_o(bus1));
  lrk_stage u_stage2 (.clk(clk), .rst_n(rst_n), .cfg(coef), .mode(MODE2),
                      .bus_i(bus1), .bus_o(bus2));
  lrk_stage u_stage3 (.clk(clk), .rst_n(rst_n), .cfg(coef), .mode(MODE3),
                      .bus_i(bus2), .bus_o(bus3));
  lrk_stage u_stage4 (.clk(clk), .rst_n(rst_n), .cfg(coef), .mode(MODE4),
                      .bus_i(bus3), .bus_o(bus4));

  lrk_comb u_comb (.clk(clk), .rst_n(rst_n), .bus_i(bus4), .res_o(res_c));

  lrk_outq u_outq (
    .clk(clk), .rst_n(rst_n), .res_i(res_c), .pop(pop),
    .out_valid(out_valid), .out_kind(out_kind), .out_row_index(out_row_index),
    .out_elem0(out_elem0), .out_elem1(out_elem1), .out_elem2(out_elem2),
    .out_saturated(out_saturated), .out_last(out_last)
  );

  // Request count stays within the queue
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("request count above queue depth");

  // A request finishes only while one is outstanding
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("request finished with none outstanding");

  // State result without last is followed directly by row 0
  a_row_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind && !out_last) |=>
    (out_valid && out_kind && out_row_index == 2'd0))
    else $error("tangent row 0 missing after state result");

  // Row 2 closes the request
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind && out_row_index == 2'd2) |-> out_last)
    else $error("row 2 without last");

endmodule

FILE: sv/lrk_stage.sv
// ----------------------------------------------------------------------------
// lrk_stage: one Runge-Kutta stage with tangent propagation
// Six register stages: field slope k, stage Jacobian K, next point, sums.
// ----------------------------------------------------------------------------
module lrk_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  lrk_pkg::coef_t cfg,
  input  lrk_pkg::mode_t mode,
  input  lrk_pkg::bus_t  bus_i,
  output lrk_pkg::bus_t  bus_o
);
  import lrk_pkg::*;

  bus_t  b1_r, b2_r, b3_r, b4_r, b5_r, b6_r;
  bus_t  b1_nxt, b2_nxt, b3_nxt, b6_nxt;

  word_t x1_r, y1_r, dy1_r, rz1_r;
  prod_t pxy1_r, pbz1_r;
  mat_t  j1_r, m1_r, j1_nxt, m1_nxt;
  sres_t r_dy, r_rz;

  word_t y2_r, t22_r;
  prod_t psdy2_r, pxrz2_r;
  prod_t pdj2_r [3][3];
  mat_t  m2_r;
  sres_t r_t2;

  word_t a3_r, t13_r, t23_r;
  mat_t  d3_r, d3_nxt, m3_r;
  sres_t r_a0, r_t1;

  prod_t pk4_r [3];
  prod_t pp4_r [3][3][3];

  vec_t  k5_r, k5_nxt;
  mat_t  kk5_r, kk5_nxt;

  // stage 1: differences, first products, J(p) and I + scaled previous K
  always_comb begin
    sres_t r_j00, r_j11, r_j12, r_j22, r_m;
    word_t hp;
    b1_nxt = bus_i;
    r_dy  = f_sub(bus_i.p[1], bus_i.p[0]);
    r_rz  = f_sub(cfg.rho, bus_i.p[2]);
    r_j00 = f_sub('0, cfg.sigma);
    r_j11 = f_sub('0, ONE_Q);
    r_j12 = f_sub('0, bus_i.p[0]);
    r_j22 = f_sub('0, cfg.beta);
    j1_nxt[0][0] = r_j00.v;
    j1_nxt[0][1] = cfg.sigma;
    j1_nxt[0][2] = '0;
    j1_nxt[1][0] = r_rz.v;
    j1_nxt[1][1] = r_j11.v;
    j1_nxt[1][2] = r_j12.v;
    j1_nxt[2][0] = bus_i.p[1];
    j1_nxt[2][1] = bus_i.p[0];
    j1_nxt[2][2] = r_j22.v;
    b1_nxt.clip_s = bus_i.clip_s | r_dy.clip | r_rz.clip;
    b1_nxt.clip_j = bus_i.clip_j | r_rz.clip | r_j00.clip | r_j11.clip |
                    r_j12.clip | r_j22.clip;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        hp = mode.halve_prev ? f_half(bus_i.kprev[r][c]) : bus_i.kprev[r][c];
        if (r == c) begin
          r_m = f_add(ONE_Q, hp);
        end else begin
          r_m = '{clip: 1'b0, v: hp};
        end
        m1_nxt[r][c] = r_m.v;
        b1_nxt.clip_j = b1_nxt.clip_j | r_m.clip;
      end
    end
  end

  // stage 2: scale the products down, issue the next products
  always_comb begin
    sres_t r_a, r_b;
    b2_nxt = b1_r;
    r_a  = f_mulfin(pxy1_r);
    r_b  = f_mulfin(pbz1_r);
    r_t2 = f_sub(r_a.v, r_b.v);
    b2_nxt.clip_s = b1_r.clip_s | r_a.clip | r_b.clip | r_t2.clip;
  end

  // stage 3: finish f(p) terms and dt*J
  always_comb begin
    sres_t r_x, r_d;
    b3_nxt = b2_r;
    r_a0 = f_mulfin(psdy2_r);
    r_x  = f_mulfin(pxrz2_r);
    r_t1 = f_sub(r_x.v, y2_r);
    b3_nxt.clip_s = b2_r.clip_s | r_a0.clip | r_x.clip | r_t1.clip;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r_d = f_mulfin(pdj2_r[r][c]);
        d3_nxt[r][c] = r_d.v;
        b3_nxt.clip_j = b3_nxt.clip_j | r_d.clip;
      end
    end
  end

  // stage 5: slope k and matrix product entries
  always_comb begin
    sres_t r_k, r_kk;
    b6_nxt = b4_r;
    for (int i = 0; i < 3; i++) begin
      r_k = f_mulfin(pk4_r[i]);
      k5_nxt[i] = r_k.v;
      b6_nxt.clip_s = b6_nxt.clip_s | r_k.clip;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r_kk = f_accfin(acc_t'(pp4_r[r][c][0]) + acc_t'(pp4_r[r][c][1]) +
                        acc_t'(pp4_r[r][c][2]));
        kk5_nxt[r][c] = r_kk.v;
        b6_nxt.clip_j = b6_nxt.clip_j | r_kk.clip;
      end
    end
  end

  // stage 6 comb: next point and weighted sums, built from stage 5 registers
  bus_t b6_in;
  always_comb begin
    sres_t r_p;
    word_t stp;
    b6_in = b5_r;
    b6_in.kprev = kk5_r;
    for (int i = 0; i < 3; i++) begin
      stp = mode.halve_next ? f_half(k5_r[i]) : k5_r[i];
      r_p = f_add(b5_r.u[i], stp);
      if (mode.use_next) begin
        b6_in.p[i] = r_p.v;
        b6_in.clip_s = b6_in.clip_s | r_p.clip;
      end else begin
        b6_in.p[i] = '0;
      end
      b6_in.ssum[i] = b5_r.ssum[i] + (mode.weight2 ? (sum_t'($signed(k5_r[i])) <<< 1) :
                                                     sum_t'($signed(k5_r[i])));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        b6_in.jsum[r][c] = b5_r.jsum[r][c] +
          (mode.weight2 ? (sum_t'($signed(kk5_r[r][c])) <<< 1) :
                          sum_t'($signed(kk5_r[r][c])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.valid <= 1'b0;
      b2_r.valid <= 1'b0;
      b3_r.valid <= 1'b0;
      b4_r.valid <= 1'b0;
      b5_r.valid <= 1'b0;
      b6_r.valid <= 1'b0;
    end else begin
      b1_r <= b1_nxt;
      x1_r <= bus_i.p[0];
      y1_r <= bus_i.p[1];
      dy1_r <= r_dy.v;
      rz1_r <= r_rz.v;
      pxy1_r <= f_mul(bus_i.p[0], bus_i.p[1]);
      pbz1_r <= f_mul(cfg.beta, bus_i.p[2]);
      j1_r <= j1_nxt;
      m1_r <= m1_nxt;

      b2_r <= b2_nxt;
      y2_r <= y1_r;
      psdy2_r <= f_mul(cfg.sigma, dy1_r);
      pxrz2_r <= f_mul(x1_r, rz1_r);
      t22_r <= r_t2.v;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pdj2_r[r][c] <= f_mul(cfg.dt, j1_r[r][c]);
        end
      end
      m2_r <= m1_r;

      b3_r <= b3_nxt;
      a3_r <= r_a0.v;
      t13_r <= r_t1.v;
      t23_r <= t22_r;
      d3_r <= d3_nxt;
      m3_r <= m2_r;

      b4_r <= b3_r;
      pk4_r[0] <= f_mul(cfg.dt, a3_r);
      pk4_r[1] <= f_mul(cfg.dt, t13_r);
      pk4_r[2] <= f_mul(cfg.dt, t23_r);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          for (int i = 0; i < 3; i++) begin
            pp4_r[r][c][i] <= f_mul(d3_r[r][i], m3_r[i][c]);
          end
        end
      end

      b5_r <= b6_nxt;
      k5_r <= k5_nxt;
      kk5_r <= kk5_nxt;

      b6_r <= b6_in;
    end
  end

  assign bus_o = b6_r;

endmodule

FILE: sv/lrk_comb.sv
// ----------------------------------------------------------------------------
// lrk_comb: final weighted average and update
// Divides the exact k sums by six and adds them to u or to the identity.
// ----------------------------------------------------------------------------
module lrk_comb (
  input  logic          clk,
  input  logic          rst_n,
  input  lrk_pkg::bus_t bus_i,
  output lrk_pkg::res_t res_o
);
  import lrk_pkg::*;

  localparam int DIV_K = SUM_W + 3;
  localparam int RW    = DIV_K - 2;
  localparam int LO_W  = (SUM_W + 1) / 2;
  localparam int HI_W  = SUM_W - LO_W;
  localparam int PL_W  = LO_W + RW;
  localparam int PH_W  = HI_W + RW;
  localparam int FULL_W = SUM_W + RW;
  localparam logic [RW-1:0] DIV_R = RW'(((65'd1 << DIV_K) + 65'd5) / 65'd6);

  typedef struct packed {
    logic valid;
    logic want;
    logic clip_s;
    logic clip_j;
    vec_t u;
  } meta_t;

  meta_t meta0, meta1_r, meta2_r, meta3_r;
  logic [SUM_W-1:0] sv [12];
  logic [SUM_W-1:0] mag1_r [12];
  logic             neg1_r [12];
  logic             neg2_r [12];
  logic [PL_W-1:0]  pl2_r [12];
  logic [PH_W-1:0]  ph2_r [12];
  word_t            avg3_r [12];
  word_t            avg_nxt [12];
  res_t             res_r, res_nxt;

  always_comb begin
    meta0 = '{valid: bus_i.valid, want: bus_i.want, clip_s: bus_i.clip_s,
              clip_j: bus_i.clip_j, u: bus_i.u};
    for (int n = 0; n < 3; n++) begin
      sv[n] = bus_i.ssum[n];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sv[3 + 3 * r + c] = bus_i.jsum[r][c];
      end
    end
  end

  // quotient by reciprocal; exact for every magnitude below 2^SUM_W
  always_comb begin
    logic [FULL_W-1:0] full;
    logic [WORD_W:0]   q;
    for (int n = 0; n < 12; n++) begin
      full = (FULL_W'(ph2_r[n]) << LO_W) + FULL_W'(pl2_r[n]);
      q = (WORD_W+1)'(full >> DIV_K);
      avg_nxt[n] = neg2_r[n] ? word_t'(-q) : word_t'(q);
    end
  end

  always_comb begin
    sres_t r_a;
    res_nxt = '{valid: meta3_r.valid, want: meta3_r.want, clip_s: meta3_r.clip_s,
                clip_j: meta3_r.clip_j, st: '0, jm: '0};
    for (int i = 0; i < 3; i++) begin
      r_a = f_add(meta3_r.u[i], avg3_r[i]);
      res_nxt.st[i] = r_a.v;
      res_nxt.clip_s = res_nxt.clip_s | r_a.clip;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == c) begin
          r_a = f_add(ONE_Q, avg3_r[3 + 3 * r + c]);
        end else begin
          r_a = '{clip: 1'b0, v: avg3_r[3 + 3 * r + c]};
        end
        res_nxt.jm[r][c] = r_a.v;
        res_nxt.clip_j = res_nxt.clip_j | r_a.clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta1_r.valid <= 1'b0;
      meta2_r.valid <= 1'b0;
      meta3_r.valid <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      meta1_r <= meta0;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
      for (int n = 0; n < 12; n++) begin
        neg1_r[n] <= sv[n][SUM_W-1];
        mag1_r[n] <= sv[n][SUM_W-1] ? (~sv[n] + 1'b1) : sv[n];
        neg2_r[n] <= neg1_r[n];
        pl2_r[n] <= PL_W'(mag1_r[n][LO_W-1:0]) * PL_W'(DIV_R);
        ph2_r[n] <= PH_W'(mag1_r[n][SUM_W-1:LO_W]) * PH_W'(DIV_R);
        avg3_r[n] <= avg_nxt[n];
      end
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

FILE: sv/lrk_outq.sv
// ----------------------------------------------------------------------------
// lrk_outq: result queue and emitter
// Holds finished items and sends the state and tangent rows one per cycle.
// ----------------------------------------------------------------------------
module lrk_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  lrk_pkg::res_t res_i,
  output logic          pop,
  output logic          out_valid,
  output logic          out_kind,
  output logic [1:0]    out_row_index,
  output lrk_pkg::word_t out_elem0,
  output lrk_pkg::word_t out_elem1,
  output lrk_pkg::word_t out_elem2,
  output logic          out_saturated,
  output logic          out_last
);
  import lrk_pkg::*;

  res_t         q_r [QDEPTH];
  logic [QAW:0] wp_r, rp_r;
  logic [1:0]   phase_r;
  logic         have, is_last;
  res_t         head;
  vec_t         sel;

  logic         out_valid_r, out_kind_r, out_sat_r, out_last_r;
  logic [1:0]   out_row_r;
  vec_t         out_elem_r;

  always_comb begin
    have = wp_r != rp_r;
    head = q_r[rp_r[QAW-1:0]];
    is_last = !head.want || (phase_r == 2'd3);
    pop = have && is_last;
    unique case (phase_r)
      2'd0: sel = head.st;
      2'd1: sel = head.jm[0];
      2'd2: sel = head.jm[1];
      default: sel = head.jm[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_i.valid) begin
      q_r[wp_r[QAW-1:0]] <= res_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      phase_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_i.valid) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (have) begin
        phase_r <= is_last ? 2'd0 : phase_r + 2'd1;
      end
      out_valid_r <= have;
      out_kind_r <= phase_r != 2'd0;
      out_row_r <= (phase_r == 2'd0) ? 2'd0 : phase_r - 2'd1;
      out_elem_r <= sel;
      out_sat_r <= (phase_r == 2'd0) ? head.clip_s : (head.clip_s | head.clip_j);
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_row_index = out_row_r;
  assign out_elem0 = out_elem_r[0];
  assign out_elem1 = out_elem_r[1];
  assign out_elem2 = out_elem_r[2];
  assign out_saturated = out_sat_r;
  assign out_last = out_last_r;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lorenz_rk4_step_with_tangent
// Drives Lorenz states through the command port under several coefficient
// settings and checks every state and tangent-row result against an
// in-bench fixed-point RK4 calculator, or a state typed in its stim row.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrk_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic      kind;
    logic [1:0] row;
    word_t     e0, e1, e2;
    logic      sat;
    logic      last;
  } rk_result_t;

  typedef struct {
    word_t x, y, z;
    logic  want;
    logic  typed;   // expected state typed in the row instead of predicted
    word_t ex, ey, ez;
  } stim_row_t;

  localparam int N_DIR = 16;
  localparam int N_RAND_PHASE = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  word_t in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_want_tangent = 1'b0;
  logic out_valid, out_kind, out_saturated, out_last;
  logic [1:0] out_row_index;
  word_t out_elem0, out_elem1, out_elem2;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  lorenz_rk4_step_with_tangent dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_want_tangent(in_want_tangent),
    .out_valid(out_valid), .out_kind(out_kind), .out_row_index(out_row_index),
    .out_elem0(out_elem0), .out_elem1(out_elem1), .out_elem2(out_elem2),
    .out_saturated(out_saturated), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Coefficient shadow, kept in step with every register write.
  longint sigma_q = 655360, rho_q = 1835008, beta_q = 174763, dt_q = 655;
  bit clip_seen;
  rk_result_t pending_results[$];
  int mismatches = 0;

  // --------------------------------------------------------------------------
  // Fixed-point calculator: exact wide math, shift/divide toward zero,
  // then saturate to the word and note any clipping.
  // --------------------------------------------------------------------------
  function automatic longint q_fin(wide_t v, int sh, int d);
    bit neg;
    wide_t m, lim;
    neg = v < 0;
    m = neg ? -v : v;
    m = (m >> sh) / d;
    lim = neg ? (wide_t'(1) <<< (WORD_W - 1)) : (wide_t'(1) <<< (WORD_W - 1)) - 1;
    if (m > lim) begin
      clip_seen = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_add(longint a, longint b);
    return q_fin(wide_t'(a) + wide_t'(b), 0, 1);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return q_fin(wide_t'(a) - wide_t'(b), 0, 1);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return q_fin(wide_t'(a) * wide_t'(b), FRAC_BITS, 1);
  endfunction

  function automatic longint q_half(longint a);
    return q_fin(wide_t'(a), 1, 1);
  endfunction

  function automatic longint q_avg6(longint a, longint b, longint c, longint d);
    return q_fin(wide_t'(a) + 2 * wide_t'(b) + 2 * wide_t'(c) + wide_t'(d), 0, 6);
  endfunction

  // One evaluation of dt * f(u).
  function automatic void lorenz_slope(input longint u[3], output longint k[3]);
    k[0] = q_mul(dt_q, q_mul(sigma_q, q_sub(u[1], u[0])));
    k[1] = q_mul(dt_q, q_sub(q_mul(u[0], q_sub(rho_q, u[2])), u[1]));
    k[2] = q_mul(dt_q, q_sub(q_mul(u[0], u[1]), q_mul(beta_q, u[2])));
  endfunction

  // dt * J(u)
  function automatic void scaled_jacobian(input longint u[3], input longint one,
                                          output longint d[3][3]);
    longint j[3][3];
    j[0][0] = q_sub(0, sigma_q); j[0][1] = sigma_q; j[0][2] = 0;
    j[1][0] = q_sub(rho_q, u[2]); j[1][1] = q_sub(0, one); j[1][2] = q_sub(0, u[0]);
    j[2][0] = u[1]; j[2][1] = u[0]; j[2][2] = q_sub(0, beta_q);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        d[r][c] = q_mul(dt_q, j[r][c]);
  endfunction

  // dt J(u) (I + prev or prev/2); the three products of an entry are summed
  // exactly before the single shift.
  function automatic void chain_jacobian(input longint u[3], input longint prev[3][3],
                                         input bit halve, input longint one,
                                         output longint res[3][3]);
    longint d[3][3], m[3][3], p;
    wide_t acc;
    scaled_jacobian(u, one, d);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        p = halve ? q_half(prev[r][c]) : prev[r][c];
        m[r][c] = (r == c) ? q_add(one, p) : p;
      end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += wide_t'(d[r][i]) * wide_t'(m[i][c]);
        res[r][c] = q_fin(acc, FRAC_BITS, 1);
      end
  endfunction

  // Predict the results of one request and queue them.
  function automatic void predict_rk4_step(word_t px, word_t py, word_t pz, logic want);
    longint u[3], k1[3], k2[3], k3[3], k4[3], u1[3], u2[3], u3[3], nu[3];
    longint j1[3][3], j2[3][3], j3[3][3], j4[3][3], pm[3][3], one, s;
    bit state_clip;
    rk_result_t res;
    clip_seen = 1'b0;
    u[0] = px; u[1] = py; u[2] = pz;
    lorenz_slope(u, k1);
    for (int i = 0; i < 3; i++) u1[i] = q_add(u[i], q_half(k1[i]));
    lorenz_slope(u1, k2);
    for (int i = 0; i < 3; i++) u2[i] = q_add(u[i], q_half(k2[i]));
    lorenz_slope(u2, k3);
    for (int i = 0; i < 3; i++) u3[i] = q_add(u[i], k3[i]);
    lorenz_slope(u3, k4);
    for (int i = 0; i < 3; i++) nu[i] = q_add(u[i], q_avg6(k1[i], k2[i], k3[i], k4[i]));
    state_clip = clip_seen;
    res.kind = 1'b0; res.row = 2'd0;
    res.e0 = word_t'(nu[0]); res.e1 = word_t'(nu[1]); res.e2 = word_t'(nu[2]);
    res.sat = state_clip; res.last = !want;
    pending_results.push_back(res);
    if (!want) return;
    one = q_fin(wide_t'(1) <<< FRAC_BITS, 0, 1);
    scaled_jacobian(u, one, j1);
    chain_jacobian(u1, j1, 1'b1, one, j2);
    chain_jacobian(u2, j2, 1'b1, one, j3);
    chain_jacobian(u3, j3, 1'b0, one, j4);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        s = q_avg6(j1[r][c], j2[r][c], j3[r][c], j4[r][c]);
        pm[r][c] = (r == c) ? q_add(one, s) : s;
      end
    for (int r = 0; r < 3; r++) begin
      res.kind = 1'b1; res.row = 2'(r);
      res.e0 = word_t'(pm[r][0]); res.e1 = word_t'(pm[r][1]); res.e2 = word_t'(pm[r][2]);
      res.sat = clip_seen; res.last = (r == 2);
      pending_results.push_back(res);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every strobed result is matched against the oldest
  // expectation; the receiver can never stall, so sample each rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rk_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d row=%0d", out_kind, out_row_index);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind || out_row_index !== exp_r.row ||
            out_elem0 !== exp_r.e0 || out_elem1 !== exp_r.e1 ||
            out_elem2 !== exp_r.e2 || out_saturated !== exp_r.sat ||
            out_last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp k%0d r%0d %h %h %h s%0d l%0d / got k%0d r%0d %h %h %h s%0d l%0d",
                     exp_r.kind, exp_r.row, exp_r.e0, exp_r.e1, exp_r.e2, exp_r.sat,
                     exp_r.last, out_kind, out_row_index, out_elem0, out_elem1,
                     out_elem2, out_saturated, out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // Present a request, hold it until accepted, then maybe drop start for a gap.
  task automatic send_request(word_t px, word_t py, word_t pz, logic want,
                              bit typed = 0, word_t ex = '0, word_t ey = '0,
                              word_t ez = '0);
    int gap;
    rk_result_t res;
    @(negedge clk);
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_want_tangent <= want;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) begin
      res.kind = 1'b0; res.row = 2'd0; res.e0 = ex; res.e1 = ey; res.e2 = ez;
      res.sat = 1'b0; res.last = !want;
      pending_results.push_back(res);
    end else begin
      predict_rk4_step(px, py, pz, want);
    end
    // Burst pacing: keep start high inside a burst, else idle a random while.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop start and wait until every expected result is back, then idle
  // with the pipeline drained.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_AW'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SIGMA: sigma_q = longint'(word_t'(val));
      REG_RHO:   rho_q = longint'(word_t'(val));
      REG_BETA:  beta_q = longint'(word_t'(val));
      default:   dt_q = longint'(val[WORD_W-2:0]);
    endcase
  endtask

  task automatic set_coefs(logic [31:0] sg, logic [31:0] rh, logic [31:0] bt,
                           logic [31:0] st);
    cfg_write(REG_SIGMA, sg);
    cfg_write(REG_RHO, rh);
    cfg_write(REG_BETA, bt);
    cfg_write(REG_STEP, st);
  endtask

  // Mostly states near the attractor (|v| <= 64), sometimes any word.
  function automatic word_t pick_coord();
    if ($urandom_range(0, 4) == 0) return word_t'($urandom);
    return word_t'(int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_request(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
  endtask

  // Directed rows: zero state, extremes of every coordinate, both flags.
  stim_row_t dir_rows[N_DIR] = '{
    '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh7fffffff, 32'sh80000000, 32'sh0, 1'b0, 1'b0, 0, 0, 0},
    '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b1, 1'b0, 0, 0, 0},
    '{32'shffff0000, 32'shffff0000, 32'shffff0000, 1'b0, 1'b0, 0, 0, 0},
    '{32'sh00010000, 32'sh0, 32'sh0, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh0, 32'sh00010000, 32'sh0, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh0, 32'sh0, 32'sh00010000, 1'b0, 1'b0, 0, 0, 0},
    '{32'sh00018000, 32'shfffe8000, 32'sh00190000, 1'b1, 1'b0, 0, 0, 0},
    '{32'shfff80000, 32'shfff40000, 32'sh001b0000, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh00000001, 32'shffffffff, 32'sh00000001, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh00640000, 32'shff9c0000, 32'sh00c80000, 1'b1, 1'b0, 0, 0, 0},
    '{32'sh55555555, 32'shaaaaaaaa, 32'sh33333333, 1'b0, 1'b0, 0, 0, 0}
  };

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset coefficients, directed rows.
    foreach (dir_rows[i])
      send_request(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].want,
                   dir_rows[i].typed, dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez);
    random_phase(N_RAND_PHASE / 2);
    drain_pipeline();

    // Largest positive coefficients; step written with its unused top bit set.
    set_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    random_phase(N_RAND_PHASE / 2);
    drain_pipeline();

    // Most negative coefficients, zero step.
    set_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
    random_phase(N_RAND_PHASE / 2);
    drain_pipeline();

    // Random coefficients with a small step, then with any step.
    set_coefs($urandom, $urandom, $urandom, $urandom_range(1, 4000));
    random_phase(N_RAND_PHASE);
    drain_pipeline();
    set_coefs($urandom, $urandom, $urandom, $urandom);
    random_phase(N_RAND_PHASE / 2);
    drain_pipeline();

    // Back to classic Lorenz coefficients; hold off once mid-phase until
    // every expected result is back.
    set_coefs(32'd655360, 32'd1835008, 32'd174763, 32'd1311);
    random_phase(N_RAND_PHASE / 2);
    drain_pipeline();
    random_phase(N_RAND_PHASE);
    drain_pipeline();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: lorenz_rk4_step_with_tangent.f
sv/lrk_pkg.sv
sv/lrk_stage.sv
sv/lrk_comb.sv
sv/lrk_outq.sv
sv/lorenz_rk4_step_with_tangent.sv
test/tb_top.sv
